### rtl/mmh2_pkg.sv
`default_nettype none

package mmh2_pkg;

  // Mixing multiplier and shift amounts of the hash.
  localparam logic [31:0] MIX_M = 32'h5bd1_e995;
  localparam int unsigned MIX_R = 24;
  localparam int unsigned FIN_A = 13;
  localparam int unsigned FIN_B = 15;

  // Default depth of the queue between front and back (a power of two, at least 2).
  localparam int unsigned QUEUE_DEPTH = 2;

  // How the back end treats the word of a beat.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FULL,
    KIND_TAIL
  } word_kind_t;

  // One classified beat as it travels from the front to the back.
  typedef struct packed {
    logic        first;
    logic        last;
    word_kind_t  kind;
    logic [31:0] seed_len;
    logic [31:0] word;
  } entry_t;

  // Back end sequencer states.
  typedef enum logic {
    ST_RUN,
    ST_FIN
  } back_state_t;

endpackage

`default_nettype wire

### rtl/mmh2_front.sv
`default_nettype none

module mmh2_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  in_first_word,
  input  wire                  in_last_word,
  input  wire  [31:0]          in_data_word,
  input  wire  [2:0]           in_valid_bytes,
  input  wire  [31:0]          in_message_length,
  input  wire  [31:0]          seed,
  input  wire                  q_full,
  output logic                 q_push,
  output mmh2_pkg::entry_t     q_entry
);

  logic             s1_v_r, s1_v_nxt;
  logic             s2_v_r, s2_v_nxt;
  mmh2_pkg::entry_t s1_r, s1_nxt;
  mmh2_pkg::entry_t s2_r, s2_nxt;
  logic             s1_adv;
  logic             s2_ready;
  logic             in_acc;
  logic [31:0]      tail_mask;
  logic [31:0]      k2_src;

  // Stage handshakes: the second stage drains into the queue when it has room.
  assign q_push   = s2_v_r && !q_full;
  assign s2_ready = !s2_v_r || !q_full;
  assign s1_adv   = s1_v_r && s2_ready;
  assign in_ready = !s1_v_r || s2_ready;
  assign in_acc   = in_valid && in_ready;
  assign q_entry  = s2_r;

  // Classify the beat by its byte count and start the word mix.
  always_comb begin
    tail_mask           = 32'h0000_0000;
    s1_nxt.first        = in_first_word;
    s1_nxt.last         = in_last_word;
    s1_nxt.seed_len     = seed ^ in_message_length;
    unique case (in_valid_bytes) inside
      3'd0: begin
        s1_nxt.kind = mmh2_pkg::KIND_NONE;
      end
      3'd1, 3'd2, 3'd3: begin
        s1_nxt.kind = mmh2_pkg::KIND_TAIL;
      end
      default: begin
        s1_nxt.kind = mmh2_pkg::KIND_FULL;
      end
    endcase
    case (in_valid_bytes)
      3'd1:    tail_mask = 32'h0000_00ff;
      3'd2:    tail_mask = 32'h0000_ffff;
      3'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'h0000_0000;
    endcase
    if (s1_nxt.kind == mmh2_pkg::KIND_FULL) begin
      s1_nxt.word = in_data_word * mmh2_pkg::MIX_M;
    end else begin
      s1_nxt.word = in_data_word & tail_mask;
    end
  end

  // Second half of the word mix for full words.
  always_comb begin
    s2_nxt = s1_r;
    k2_src = s1_r.word ^ (s1_r.word >> mmh2_pkg::MIX_R);
    if (s1_r.kind == mmh2_pkg::KIND_FULL) begin
      s2_nxt.word = k2_src * mmh2_pkg::MIX_M;
    end
  end

  // Stage valid flags.
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (s1_adv) begin
      s2_v_nxt = 1'b1;
    end else if (q_push) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/mmh2_queue.sv
`default_nettype none

module mmh2_queue #(
  parameter int unsigned DEPTH = mmh2_pkg::QUEUE_DEPTH
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  wire mmh2_pkg::entry_t push_entry,
  output logic                  full,
  input  wire                   pop,
  output mmh2_pkg::entry_t      pop_entry,
  output logic                  empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mmh2_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign pop_entry = mem_r[rd_ptr_r];

  // Pointer and fill count updates; the depth is a power of two so pointers wrap.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // The fill count never goes past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  // Nothing is taken from an empty queue or pushed into a full one without a pop.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && full) |-> pop)
    else $error("queue push while full");

endmodule

`default_nettype wire

### rtl/mmh2_back.sv
`default_nettype none

module mmh2_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_empty,
  input  wire mmh2_pkg::entry_t q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [31:0]           out_hash_value
);

  mmh2_pkg::back_state_t state_r, state_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] out_hash_r;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;
  logic        load_out;
  logic [31:0] base;
  logic [31:0] fin_x;
  logic [31:0] mul_a;
  logic [31:0] prod;

  assign out_free       = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mmh2_pkg::ST_RUN: begin
        if (!q_empty && q_entry.last) begin
          state_nxt = mmh2_pkg::ST_FIN;
        end
      end
      mmh2_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = mmh2_pkg::ST_RUN;
        end
      end
      default: state_nxt = mmh2_pkg::ST_RUN;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      mmh2_pkg::ST_RUN: q_pop    = !q_empty;
      mmh2_pkg::ST_FIN: load_out = out_free;
      default: begin
        q_pop    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // One shared multiplier: hash recurrence while running, finalization otherwise.
  always_comb begin
    base  = q_entry.first ? q_entry.seed_len : h_r;
    fin_x = h_r ^ (h_r >> mmh2_pkg::FIN_A);
    if (state_r == mmh2_pkg::ST_FIN) begin
      mul_a = fin_x;
    end else if (q_entry.kind == mmh2_pkg::KIND_TAIL) begin
      mul_a = base ^ q_entry.word;
    end else begin
      mul_a = base;
    end
    prod = mul_a * mmh2_pkg::MIX_M;
  end

  // Running hash update.
  always_comb begin
    h_nxt = h_r;
    if (q_pop) begin
      case (q_entry.kind)
        mmh2_pkg::KIND_FULL: h_nxt = prod ^ q_entry.word;
        mmh2_pkg::KIND_TAIL: h_nxt = prod;
        default:             h_nxt = base;
      endcase
    end
  end

  // Result register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmh2_pkg::ST_RUN;
      h_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hash_r <= prod ^ (prod >> mmh2_pkg::FIN_B);
    end
  end

  // Taking a last beat always leads into finalization.
  a_last_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_entry.last) |=> (state_r == mmh2_pkg::ST_FIN))
    else $error("last beat did not start finalization");

  // Finalization waits while a result is still pending.
  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mmh2_pkg::ST_FIN && out_valid_r && !out_ready)
      |=> (state_r == mmh2_pkg::ST_FIN && $stable(out_hash_r)))
    else $error("pending result overwritten");

  // The running hash does not move during finalization.
  a_hash_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mmh2_pkg::ST_FIN) |=> $stable(h_r))
    else $error("running hash changed during finalization");

endmodule

`default_nettype wire

### rtl/murmur2_hash_32_top.sv
// A beat passes front stages s1 and s2 and the queue before the back end takes it; a
// message's hash is finalized after its last beat is taken, and offered by the result register.
// Throughput: one beat per cycle inside a message unless the queue or the result side stalls; a last
// beat holds the shared back-end multiplier for finalization, and no beat leaves the queue meanwhile.
// Reset (synchronous, rst_n low): seed and running hash clear to zero, pipeline, queue
// and result register empty.
`default_nettype none

module murmur2_hash_32_top #(
  parameter int unsigned QUEUE_DEPTH = mmh2_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_seed,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_first_word,
  input  wire         in_last_word,
  input  wire  [31:0] in_data_word,
  input  wire  [2:0]  in_valid_bytes,
  input  wire  [31:0] in_message_length,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_hash_value
);

  logic [31:0]      seed_r;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  mmh2_pkg::entry_t push_entry;
  mmh2_pkg::entry_t pop_entry;

  // Seed register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_we) begin
      seed_r <= cfg_seed;
    end
  end

  // Front: accepts beats, classifies them and premixes full words.
  mmh2_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_first_word     (in_first_word),
    .in_last_word      (in_last_word),
    .in_data_word      (in_data_word),
    .in_valid_bytes    (in_valid_bytes),
    .in_message_length (in_message_length),
    .seed              (seed_r),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (push_entry)
  );

  // Queue decoupling the front from the back.
  mmh2_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  // Back: hash recurrence, finalization and result register.
  mmh2_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_entry        (pop_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

endmodule

`default_nettype wire

### dv/murmur2_hash_32_top_tb.sv
`timescale 1ns / 100ps

module murmur2_hash_32_top_tb;

  localparam logic [31:0] HASH_MULT = 32'h5bd1_e995;
  localparam int unsigned WORD_SHIFT = 24;
  localparam int unsigned FINAL_SHIFT_A = 13;
  localparam int unsigned FINAL_SHIFT_B = 15;
  localparam int unsigned FULL_WORD = 4;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_seed = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_first_word = 1'b0;
  logic        in_last_word = 1'b0;
  logic [31:0] in_data_word = '0;
  logic [2:0]  in_valid_bytes = '0;
  logic [31:0] in_message_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_hash_value;

  // Predictor state and the hashes still owed by the block.
  logic [31:0] seed_model = '0;
  logic [31:0] hash_model = '0;
  logic [31:0] expected_hashes[$];

  int unsigned error_count = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  murmur2_hash_32_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_seed         (cfg_seed),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_first_word    (in_first_word),
    .in_last_word     (in_last_word),
    .in_data_word     (in_data_word),
    .in_valid_bytes   (in_valid_bytes),
    .in_message_length(in_message_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hash_value   (out_hash_value)
  );

  // Free-running clock with a 12 ns period.
  initial begin
    forever #6 clk = ~clk;
  end

  // Mixes one full word into the running hash.
  function automatic logic [31:0] mix_full_word(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] m;
    m = k * HASH_MULT;
    m = m ^ (m >> WORD_SHIFT);
    m = m * HASH_MULT;
    return (h * HASH_MULT) ^ m;
  endfunction

  // Final avalanche applied before the hash leaves the block.
  function automatic logic [31:0] finalize_hash(input logic [31:0] h);
    logic [31:0] f;
    f = h ^ (h >> FINAL_SHIFT_A);
    f = f * HASH_MULT;
    return f ^ (f >> FINAL_SHIFT_B);
  endfunction

  // Track seed writes and predict the hash for every accepted input beat.
  always @(posedge clk) begin : predict_hash
    logic [31:0] h;
    int unsigned nbytes;
    if (cfg_we) begin
      seed_model = cfg_seed;
    end
    if (rst_n && in_valid && in_ready) begin
      nbytes = (in_valid_bytes > FULL_WORD) ? FULL_WORD : in_valid_bytes;
      h = in_first_word ? (seed_model ^ in_message_length) : hash_model;
      if (nbytes == FULL_WORD) begin
        h = mix_full_word(h, in_data_word);
      end else if (nbytes != 0) begin
        // A short word keeps only its low bytes, then gets one multiply.
        h = (h ^ (in_data_word & (32'hFFFF_FFFF >> (8 * (FULL_WORD - nbytes))))) * HASH_MULT;
      end
      hash_model = h;
      if (in_last_word) begin
        expected_hashes.push_back(finalize_hash(h));
      end
    end
  end

  // Compare each result beat with the oldest predicted hash.
  always @(posedge clk) begin : check_hash
    logic [31:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_hashes.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("unexpected hash beat %08h", out_hash_value);
        end
      end else begin
        want = expected_hashes.pop_front();
        if (out_hash_value !== want) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("hash mismatch: expected %08h, got %08h", want, out_hash_value);
          end
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Offers one beat after a random gap and holds it until it is taken.
  task automatic send_beat(input logic is_first, input logic is_last, input logic [2:0] nbytes,
                           input logic [31:0] word, input logic [31:0] length);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_word <= is_first;
    in_last_word <= is_last;
    in_valid_bytes <= nbytes;
    in_data_word <= word;
    in_message_length <= length;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    // Beats that the block simply ignores are not counted.
    if (!(nbytes == 0 && !is_first && !is_last)) begin
      beats_sent++;
    end
  endtask

  // Stops sending and waits until every predicted hash has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_hashes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the seed register; only called while the block is idle.
  task automatic write_seed(input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_seed <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sends one message with random words, tail and length; drop_first clears the first flag.
  task automatic send_random_message(input bit drop_first);
    int unsigned n_full;
    int unsigned i;
    logic [2:0] tail;
    logic [2:0] nb;
    logic [31:0] length;
    n_full = ($urandom_range(19) == 0) ? $urandom_range(40, 16) : $urandom_range(6);
    tail = 3'($urandom_range(3));
    length = 4 * n_full + tail;
    if ($urandom_range(9) == 0) begin
      length = $urandom();
    end
    if (n_full == 0 && tail == 0) begin
      send_beat(!drop_first, 1'b1, 3'd0, $urandom(), length);
    end else begin
      for (i = 0; i < n_full; i++) begin
        nb = 3'(FULL_WORD);
        if ($urandom_range(15) == 0) begin
          nb = 3'($urandom_range(7, 5));
        end
        send_beat((i == 0) && !drop_first, (i == n_full - 1) && (tail == 0), nb, $urandom(),
                  length);
      end
      if (tail != 0) begin
        send_beat((n_full == 0) && !drop_first, 1'b1, tail, $urandom(), length);
      end
    end
  endtask

  // Mostly clean messages, some without a first beat, some random beats.
  task automatic run_random_phase(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    start = beats_sent;
    while (beats_sent - start < target) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        send_random_message(1'b0);
      end else if (pick < 90) begin
        send_random_message(1'b1);
      end else begin
        send_beat(1'($urandom_range(1)), 1'($urandom_range(1)), 3'($urandom_range(7)),
                  $urandom(), $urandom());
      end
    end
    wait_for_results();
  endtask

  // Corner cases of tails, lengths and message framing with the reset seed.
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // Continue from the reset hash without a first beat.
    send_beat(1'b0, 1'b0, 3'd4, 32'h0123_4567, 32'h0);
    send_beat(1'b0, 1'b1, 3'd2, 32'hFFFF_FFFF, 32'h0);
    // Empty messages at both length extremes.
    send_beat(1'b1, 1'b1, 3'd0, 32'h0, 32'h0);
    send_beat(1'b1, 1'b1, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Single-beat messages of every size, some with junk above the valid bytes.
    send_beat(1'b1, 1'b1, 3'd1, 32'hFFFF_FFFF, 32'd1);
    send_beat(1'b1, 1'b1, 3'd2, 32'h0000_8001, 32'd2);
    send_beat(1'b1, 1'b1, 3'd3, 32'hFFFF_FFFF, 32'd3);
    send_beat(1'b1, 1'b1, 3'd4, 32'hFFFF_FFFF, 32'd4);
    send_beat(1'b1, 1'b1, 3'd4, 32'h0, 32'd4);
    // An ignored empty word and a short word in the middle of a message.
    send_beat(1'b1, 1'b0, 3'd4, 32'h8000_0001, 32'd13);
    send_beat(1'b0, 1'b0, 3'd4, 32'hFFFF_FFFF, 32'd0);
    send_beat(1'b0, 1'b0, 3'd0, 32'hA5A5_A5A5, 32'd0);
    send_beat(1'b0, 1'b0, 3'd2, 32'h1234_ABCD, 32'd0);
    send_beat(1'b0, 1'b1, 3'd3, 32'h00C0_FFEE, 32'd0);
    // Byte counts above four behave as a full word.
    send_beat(1'b1, 1'b0, 3'd5, 32'h7FFF_FFFE, 32'hFFFF_FFFF);
    send_beat(1'b0, 1'b0, 3'd6, 32'h5555_AAAA, 32'h0);
    send_beat(1'b0, 1'b1, 3'd7, 32'hAAAA_5555, 32'h0);
    // Carry on after a finished message without a new first beat.
    send_beat(1'b0, 1'b1, 3'd4, 32'hDEAD_BEEF, 32'h0);
    // A second first beat restarts the message.
    send_beat(1'b1, 1'b0, 3'd4, 32'h1357_9BDF, 32'd8);
    send_beat(1'b1, 1'b1, 3'd1, 32'h0000_00FF, 32'd1);
    // Length that does not match the bytes delivered.
    send_beat(1'b1, 1'b1, 3'd4, 32'h2468_ACE0, 32'h7FFF_FFFF);
    wait_for_results();
  endtask

  // Seed extremes and a random seed, each with a few messages.
  task automatic test_seed_extremes();
    logic [31:0] seeds[4];
    int unsigned i;
    seeds[0] = 32'hFFFF_FFFF;
    seeds[1] = 32'h0000_0000;
    seeds[2] = 32'h8000_0000;
    seeds[3] = $urandom();
    send_idle_pct = 27;
    recv_stall_pct = 27;
    for (i = 0; i < 4; i++) begin
      write_seed(seeds[i]);
      send_beat(1'b1, 1'b1, 3'd0, $urandom(), $urandom());
      send_random_message(1'b0);
      send_random_message(1'b0);
      wait_for_results();
    end
  endtask

  task automatic test_full_rate();
    write_seed($urandom());
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random_phase(205);
  endtask

  task automatic test_sparse_input();
    write_seed($urandom());
    send_idle_pct = 77;
    recv_stall_pct = 0;
    run_random_phase(205);
  endtask

  task automatic test_output_stall();
    write_seed($urandom());
    send_idle_pct = 0;
    recv_stall_pct = 77;
    run_random_phase(205);
  endtask

  task automatic test_mixed_idling();
    write_seed($urandom());
    send_idle_pct = 27;
    recv_stall_pct = 27;
    run_random_phase(205);
  endtask

  // Long result hold-off while beats keep coming, so the input side backs up.
  task automatic test_output_backpressure();
    int unsigned i;
    write_seed($urandom());
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    for (i = 0; i < 12; i++) begin
      send_random_message(1'b0);
    end
    wait_for_results();
  endtask

  // Reset, the tests in turn, then the verdict.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_seed_extremes();
    test_full_rate();
    test_sparse_input();
    test_output_stall();
    test_mixed_idling();
    test_output_backpressure();
    if (error_count == 0 && expected_hashes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
